// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled during arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MVP_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MVP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mvp_pkg.sv -----
// ----------------------------------------------------------------------------
// mvp_pkg
// shared types and constants of the motion vector median predictor
// ----------------------------------------------------------------------------
package mvp_pkg;

	// defaults for the top-level parameters
	localparam int MAX_BLOCKS_ACROSS_DEF = 64;
	localparam int VECTOR_BITS_DEF       = 12;

	// fixed field widths
	localparam int DELTA_BITS    = 12;
	localparam int POS_BITS      = 6;
	localparam int CFG_DATA_BITS = 7;
	localparam int CFG_INDEX_BITS = 2;

	// frame height limit
	localparam int MAX_BLOCKS_DOWN = 64;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCKS_ACROSS = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCKS_DOWN   = 2'd1;

	// register reset values
	localparam logic [CFG_DATA_BITS-1:0] BLOCKS_ACROSS_RST = 7'd32;
	localparam logic [CFG_DATA_BITS-1:0] BLOCKS_DOWN_RST   = 7'd24;

	// which neighbours of a block exist
	typedef struct packed {
		logic have_left;
		logic have_up;
		logic have_ur;
	} nbr_t;

endpackage

// ----- rtl/motion_vector_median_predictor_unit.sv -----
// ----------------------------------------------------------------------------
// motion_vector_median_predictor_unit
// Rebuilds block motion vectors of an inter frame in raster order. Each
// accepted word is one block's symbol (reuse flag or x/y delta); each result
// word carries the saturated vector, the block position and a frame_done flag
// on the last block. The block takes one word per clock and gives one per
// clock while the receiver does not stall; a result word passes through
// stage one and then the output register before it is on the port. The
// throughput is set by the left-neighbour loop: predictor select, delta add
// and saturation are combinational in stage one and feed the next block
// directly. The row above lives in one memory (two read ports, one write
// port, registered read) read at accept and written when the block leaves
// stage one; a block that reads the entry the previous block is writing
// takes the vector from the left register instead. The row memory needs no
// clearing pass after reset: every entry read in a frame was written in the
// row above. Registers: index 0 blocks_across, index 1 blocks_down, to be
// written by the user only while the unit is idle; the unit itself does not
// enforce this. Out-of-range values act as the nearest legal value, and a
// position past a shrunken frame counts as the last one.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module motion_vector_median_predictor_unit #(
	parameter int MAX_BLOCKS_ACROSS = mvp_pkg::MAX_BLOCKS_ACROSS_DEF,
	parameter int VECTOR_BITS       = mvp_pkg::VECTOR_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// configuration write channel
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [mvp_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
	input  logic [mvp_pkg::CFG_DATA_BITS-1:0]         cfg_data,
	// symbol channel
	input  logic                                      blk_valid,
	output logic                                      blk_stall,
	input  logic                                      reuse_prediction,
	input  logic signed [mvp_pkg::DELTA_BITS-1:0]     delta_x,
	input  logic signed [mvp_pkg::DELTA_BITS-1:0]     delta_y,
	// vector channel
	output logic                                      vec_valid,
	input  logic                                      vec_stall,
	output logic signed [VECTOR_BITS-1:0]             vector_x,
	output logic signed [VECTOR_BITS-1:0]             vector_y,
	output logic [mvp_pkg::POS_BITS-1:0]              block_column,
	output logic [mvp_pkg::POS_BITS-1:0]              block_line,
	output logic                                      frame_done
);

	localparam int CW = $clog2(MAX_BLOCKS_ACROSS);
	// compare width for column against blocks_across
	localparam int AW = (CW + 1 > mvp_pkg::CFG_DATA_BITS) ? CW + 1 : mvp_pkg::CFG_DATA_BITS;
	localparam int DW = mvp_pkg::CFG_DATA_BITS;
	localparam int MW = 2 * VECTOR_BITS;

	// configuration registers
	logic [DW-1:0] across_q, down_q;

	// position of the next block
	logic [CW-1:0]                col_q;
	logic [mvp_pkg::POS_BITS-1:0] line_q;

	// clamped frame size and position flags of the incoming block
	logic [AW-1:0]  across_c;
	logic [DW-1:0]  down_c;
	logic           last_col, last_line;
	mvp_pkg::nbr_t  nbr_in;
	logic [CW-1:0]  ur_addr;

	// handshake
	logic blk_acc, s1_adv, out_take;

	// stage one: block in flight with its row-above data
	logic                               valid_s1;
	logic                               reuse_s1;
	logic signed [mvp_pkg::DELTA_BITS-1:0] dx_s1, dy_s1;
	logic [CW-1:0]                      col_s1;
	logic [mvp_pkg::POS_BITS-1:0]       line_s1;
	mvp_pkg::nbr_t                      nbr_s1;
	logic                               done_s1;
	logic                               byp_up_s1, byp_ur_s1;
	logic [MW-1:0]                      up_rd_s1, ur_rd_s1;

	// row-above memory, x in the upper half, y in the lower
	logic [MW-1:0] row_mem [MAX_BLOCKS_ACROSS];

	// vector of the previous block
	logic signed [VECTOR_BITS-1:0] left_x_q, left_y_q;

	// neighbour values after bypass, and the new vector
	logic signed [VECTOR_BITS-1:0] up_x, up_y, ur_x, ur_y, vx_new, vy_new;

	// output register
	logic                          vec_valid_q;
	logic signed [VECTOR_BITS-1:0] vx_q, vy_q;
	logic [CW-1:0]                 out_col_q;
	logic [mvp_pkg::POS_BITS-1:0]  out_line_q;
	logic                          out_done_q;

	// ------------------------------------------------------------------
	// configuration port, always ready
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			across_q <= mvp_pkg::BLOCKS_ACROSS_RST;
			down_q   <= mvp_pkg::BLOCKS_DOWN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mvp_pkg::REG_BLOCKS_ACROSS: across_q <= cfg_data;
				mvp_pkg::REG_BLOCKS_DOWN:   down_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// frame geometry: clamp registers and classify the next block
	// ------------------------------------------------------------------
	always_comb begin
		if (across_q == '0) begin
			across_c = AW'(1);
		end else if (AW'(across_q) > AW'(MAX_BLOCKS_ACROSS)) begin
			across_c = AW'(MAX_BLOCKS_ACROSS);
		end else begin
			across_c = AW'(across_q);
		end

		if (down_q == '0) begin
			down_c = DW'(1);
		end else if (down_q > DW'(mvp_pkg::MAX_BLOCKS_DOWN)) begin
			down_c = DW'(mvp_pkg::MAX_BLOCKS_DOWN);
		end else begin
			down_c = down_q;
		end

		// a position at or past the end counts as the last one
		last_col  = (AW'(col_q) + AW'(1)) >= across_c;
		last_line = (DW'(line_q) + DW'(1)) >= down_c;

		nbr_in.have_left = (col_q != '0);
		nbr_in.have_up   = (line_q != '0);
		nbr_in.have_ur   = nbr_in.have_up && !last_col;

		// up-right address, kept inside the memory on the last column
		ur_addr = last_col ? col_q : col_q + CW'(1);
	end

	// ------------------------------------------------------------------
	// handshake: stage one moves on unless the output word is held
	// ------------------------------------------------------------------
	assign out_take  = vec_valid_q && !vec_stall;
	assign s1_adv    = valid_s1 && (!vec_valid_q || !vec_stall);
	assign blk_stall = valid_s1 && !s1_adv;
	assign blk_acc   = blk_valid && !blk_stall;

	// ------------------------------------------------------------------
	// position counters advance on every accepted word
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			line_q <= '0;
		end else if (blk_acc) begin
			if (last_col) begin
				col_q  <= '0;
				line_q <= last_line ? '0 : line_q + mvp_pkg::POS_BITS'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// row memory: read up and up-right at accept, write the new vector
	// when the block leaves stage one (read returns the old contents)
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			row_mem[col_s1] <= {vx_new, vy_new};
		end
		if (blk_acc) begin
			up_rd_s1 <= row_mem[col_q];
			ur_rd_s1 <= row_mem[ur_addr];
		end
	end

	// ------------------------------------------------------------------
	// stage one registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (blk_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (blk_acc) begin
			reuse_s1 <= reuse_prediction;
			dx_s1    <= delta_x;
			dy_s1    <= delta_y;
			col_s1   <= col_q;
			line_s1  <= line_q;
			nbr_s1   <= nbr_in;
			done_s1  <= last_col && last_line;
			// a block still in stage one is written at this same edge, so its
			// vector lands in the left register: take it from there
			byp_up_s1 <= valid_s1 && (col_s1 == col_q);
			byp_ur_s1 <= valid_s1 && (col_s1 == ur_addr);
		end
	end

	always_comb begin
		up_x = byp_up_s1 ? left_x_q : $signed(up_rd_s1[MW-1:VECTOR_BITS]);
		up_y = byp_up_s1 ? left_y_q : $signed(up_rd_s1[VECTOR_BITS-1:0]);
		ur_x = byp_ur_s1 ? left_x_q : $signed(ur_rd_s1[MW-1:VECTOR_BITS]);
		ur_y = byp_ur_s1 ? left_y_q : $signed(ur_rd_s1[VECTOR_BITS-1:0]);
	end

	// predictor, delta add and saturation, one unit per component
	mvp_pred #(
		.VECTOR_BITS(VECTOR_BITS)
	) u_pred_x (
		.left     (left_x_q),
		.up       (up_x),
		.up_right (ur_x),
		.nbr      (nbr_s1),
		.reuse    (reuse_s1),
		.delta    (dx_s1),
		.vec      (vx_new)
	);

	mvp_pred #(
		.VECTOR_BITS(VECTOR_BITS)
	) u_pred_y (
		.left     (left_y_q),
		.up       (up_y),
		.up_right (ur_y),
		.nbr      (nbr_s1),
		.reuse    (reuse_s1),
		.delta    (dy_s1),
		.vec      (vy_new)
	);

	// ------------------------------------------------------------------
	// left neighbour: the last finished vector
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_x_q <= '0;
			left_y_q <= '0;
		end else if (s1_adv) begin
			left_x_q <= vx_new;
			left_y_q <= vy_new;
		end
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_valid_q <= 1'b0;
		end else if (s1_adv) begin
			vec_valid_q <= 1'b1;
		end else if (out_take) begin
			vec_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			vx_q       <= vx_new;
			vy_q       <= vy_new;
			out_col_q  <= col_s1;
			out_line_q <= line_s1;
			out_done_q <= done_s1;
		end
	end

	assign vec_valid    = vec_valid_q;
	assign vector_x     = vx_q;
	assign vector_y     = vy_q;
	assign block_column = mvp_pkg::POS_BITS'(out_col_q);
	assign block_line   = out_line_q;
	assign frame_done   = out_done_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// the last block of a frame sends both counters back to the origin
	`MVP_ASSERT_NEXT(a_frame_wrap, blk_acc && last_col && last_line, col_q == '0 && line_q == '0, "position did not wrap after last block")
	// after each stage-one advance, left register and output word carry the same finished vector
	`MVP_ASSERT_NEXT(a_left_matches_out, s1_adv, vec_valid_q && left_x_q == vx_q && left_y_q == vy_q, "left vector differs from delivered vector")
	// input is held back only when both stages are occupied and the receiver stalls
	`MVP_ASSERT_IMPLY(a_stall_only_when_full, blk_stall, valid_s1 && vec_valid_q && vec_stall, "input stalled with room in the pipeline")

endmodule

// ----- rtl/mvp_pred.sv -----
// ----------------------------------------------------------------------------
// mvp_pred
// one vector component: predictor selection, delta add and saturation
// ----------------------------------------------------------------------------
module mvp_pred #(
	parameter int VECTOR_BITS = mvp_pkg::VECTOR_BITS_DEF
) (
	input  logic signed [VECTOR_BITS-1:0]         left,
	input  logic signed [VECTOR_BITS-1:0]         up,
	input  logic signed [VECTOR_BITS-1:0]         up_right,
	input  mvp_pkg::nbr_t                         nbr,
	input  logic                                  reuse,
	input  logic signed [mvp_pkg::DELTA_BITS-1:0] delta,
	output logic signed [VECTOR_BITS-1:0]         vec
);

	localparam int SW = ((VECTOR_BITS > mvp_pkg::DELTA_BITS) ?
		VECTOR_BITS : mvp_pkg::DELTA_BITS) + 1;
	localparam logic signed [SW-1:0] SAT_HI =
		{{(SW - VECTOR_BITS + 1){1'b0}}, {(VECTOR_BITS - 1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

	logic signed [VECTOR_BITS-1:0] lo_lu, hi_lu, hi_uur, lo_hr, med, pred;
	logic signed [SW-1:0]          sum;

	// median as max(min(l,u), min(max(l,u), ur))
	always_comb begin
		lo_lu  = (left < up) ? left : up;
		hi_lu  = (left > up) ? left : up;
		hi_uur = (up > up_right) ? up : up_right;
		lo_hr  = (hi_lu < up_right) ? hi_lu : up_right;
		med    = (lo_lu > lo_hr) ? lo_lu : lo_hr;
	end

	always_comb begin
		if (!nbr.have_left && !nbr.have_up) begin
			pred = '0;
		end else if (!nbr.have_up) begin
			pred = left;
		end else if (!nbr.have_left) begin
			pred = nbr.have_ur ? hi_uur : up;
		end else if (!nbr.have_ur) begin
			pred = hi_lu;
		end else begin
			pred = med;
		end
	end

	always_comb begin
		sum = SW'(pred) + SW'(delta);
		if (reuse) begin
			vec = pred;
		end else if (sum > SAT_HI) begin
			vec = VECTOR_BITS'(SAT_HI);
		end else if (sum < SAT_LO) begin
			vec = VECTOR_BITS'(SAT_LO);
		end else begin
			vec = VECTOR_BITS'(sum);
		end
	end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Checks the motion vector median predictor against a cycle-free model of
// its own, kept in step word by word at the symbol handshake. Directed
// frames cover the neighbour cases, saturation, frame wrap, register
// clamping and a frame shrunk in the middle of a frame. Random frames
// of many shapes follow under three idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int DB         = mvp_pkg::DELTA_BITS;
	localparam int VB         = mvp_pkg::VECTOR_BITS_DEF;
	localparam int PB         = mvp_pkg::POS_BITS;
	localparam int CB         = mvp_pkg::CFG_DATA_BITS;
	localparam int ACROSS_MAX = mvp_pkg::MAX_BLOCKS_ACROSS_DEF;
	localparam int DOWN_MAX   = mvp_pkg::MAX_BLOCKS_DOWN;
	localparam int VEC_HI     = (1 << (VB - 1)) - 1;
	localparam int VEC_LO     = -VEC_HI - 1;

	localparam logic signed [DB-1:0] DELTA_MAX = {1'b0, {(DB-1){1'b1}}};
	localparam logic signed [DB-1:0] DELTA_MIN = {1'b1, {(DB-1){1'b0}}};

	// one vector word as the block should emit it
	typedef struct {
		logic signed [VB-1:0]           vx;
		logic signed [VB-1:0]           vy;
		logic [mvp_pkg::POS_BITS-1:0]   col;
		logic [mvp_pkg::POS_BITS-1:0]   blk_line;
		logic                           done;
	} mv_word_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	// block ports, all inputs known from time zero
	logic                                   cfg_valid = 1'b0;
	logic                                   cfg_ready;
	logic [mvp_pkg::CFG_INDEX_BITS-1:0]     cfg_index = '0;
	logic [mvp_pkg::CFG_DATA_BITS-1:0]      cfg_data  = '0;
	logic                                   blk_valid = 1'b0;
	logic                                   blk_stall;
	logic                                   reuse_prediction = 1'b0;
	logic signed [DB-1:0]                   delta_x = '0;
	logic signed [DB-1:0]                   delta_y = '0;
	logic                                   vec_valid;
	logic                                   vec_stall = 1'b0;
	logic signed [VB-1:0]                   vector_x;
	logic signed [VB-1:0]                   vector_y;
	logic [mvp_pkg::POS_BITS-1:0]           block_column;
	logic [mvp_pkg::POS_BITS-1:0]           block_line;
	logic                                   frame_done;

	motion_vector_median_predictor_unit uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.blk_valid        (blk_valid),
		.blk_stall        (blk_stall),
		.reuse_prediction (reuse_prediction),
		.delta_x          (delta_x),
		.delta_y          (delta_y),
		.vec_valid        (vec_valid),
		.vec_stall        (vec_stall),
		.vector_x         (vector_x),
		.vector_y         (vector_y),
		.block_column     (block_column),
		.block_line       (block_line),
		.frame_done       (frame_done)
	);

	// idle and stall odds in percent, changed per phase
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// vectors waiting to come out, oldest first
	mv_word_t expected_vectors[$];
	int       mismatch_count = 0;

	// mirror of the block state: row above, left neighbour, position, registers
	int above_x [ACROSS_MAX];
	int above_y [ACROSS_MAX];
	int left_x       = 0;
	int left_y       = 0;
	int col_count    = 0;
	int line_count   = 0;
	int frame_across = 32;
	int frame_down   = 24;

	function automatic int max_of(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	function automatic int median_of(input int p, input int q, input int r);
		int lo_pq;
		lo_pq = (p < q) ? p : q;
		return max_of(lo_pq, (max_of(p, q) < r) ? max_of(p, q) : r);
	endfunction

	function automatic int clip_vec(input int v);
		if (v > VEC_HI)
			return VEC_HI;
		if (v < VEC_LO)
			return VEC_LO;
		return v;
	endfunction

	// next vector of the frame from one symbol word; advances the mirror
	function automatic mv_word_t predict_vector(input logic reuse,
			input logic signed [DB-1:0] dx, input logic signed [DB-1:0] dy);
		int       across;
		int       down;
		int       col;
		int       row;
		int       px;
		int       py;
		int       vx;
		int       vy;
		logic     last_col;
		logic     last_line;
		logic     has_left;
		logic     has_up;
		logic     has_ur;
		mv_word_t w;

		// out-of-range register values act as the nearest legal size
		across = (frame_across < 1) ? 1 :
			(frame_across > ACROSS_MAX) ? ACROSS_MAX : frame_across;
		down   = (frame_down < 1) ? 1 : (frame_down > DOWN_MAX) ? DOWN_MAX : frame_down;
		col    = (col_count >= ACROSS_MAX) ? ACROSS_MAX - 1 : col_count;
		row    = line_count;

		// a position past a shrunken frame counts as the last one
		last_col  = (col + 1 >= across);
		last_line = (row + 1 >= down);
		has_left  = (col > 0);
		has_up    = (row > 0);
		has_ur    = has_up && !last_col;

		if (!has_left && !has_up) begin
			px = 0;
			py = 0;
		end else if (!has_up) begin
			px = left_x;
			py = left_y;
		end else if (!has_left) begin
			px = has_ur ? max_of(above_x[col], above_x[col + 1]) : above_x[col];
			py = has_ur ? max_of(above_y[col], above_y[col + 1]) : above_y[col];
		end else if (!has_ur) begin
			px = max_of(left_x, above_x[col]);
			py = max_of(left_y, above_y[col]);
		end else begin
			px = median_of(left_x, above_x[col], above_x[col + 1]);
			py = median_of(left_y, above_y[col], above_y[col + 1]);
		end

		if (reuse) begin
			vx = px;
			vy = py;
		end else begin
			vx = clip_vec(px + int'(dx));
			vy = clip_vec(py + int'(dy));
		end

		above_x[col] = vx;
		above_y[col] = vy;
		left_x       = vx;
		left_y       = vy;

		w.vx       = VB'(vx);
		w.vy       = VB'(vy);
		w.col      = PB'(col);
		w.blk_line = PB'(row);
		w.done     = last_col && last_line;

		if (last_col) begin
			col_count  = 0;
			line_count = last_line ? 0 : row + 1;
		end else begin
			col_count = col + 1;
		end
		return w;
	endfunction

	// mostly small deltas so vectors wander, with full range and extremes mixed in
	function automatic logic signed [DB-1:0] random_delta();
		int pick;
		pick = $urandom_range(99);
		if (pick < 40)
			return DB'(int'($urandom_range(31)) - 16);
		if (pick < 70)
			return DB'(int'($urandom_range(1023)) - 512);
		if (pick < 90)
			return DB'($urandom());
		return $urandom_range(1) ? DELTA_MAX : DELTA_MIN;
	endfunction

	// receiver side: random stall every cycle at the current odds
	always @(posedge clk)
		vec_stall <= ($urandom_range(99) < recv_stall_pct);

	// vector checker, compares every accepted word with the oldest prediction
	always @(posedge clk) begin
		mv_word_t want;
		if (arst_n && vec_valid && !vec_stall) begin
			if (expected_vectors.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display({"%0t: vector word with none pending: ",
						"x %0d y %0d col %0d line %0d done %0b"},
						$realtime, vector_x, vector_y, block_column, block_line,
						frame_done);
			end else begin
				want = expected_vectors.pop_front();
				if (vector_x !== want.vx || vector_y !== want.vy ||
						block_column !== want.col ||
						block_line !== want.blk_line || frame_done !== want.done) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"%0t: vector mismatch: ",
							"exp x %0d y %0d col %0d line %0d done %0b, ",
							"got x %0d y %0d col %0d line %0d done %0b"},
							$realtime, want.vx, want.vy, want.col, want.blk_line,
							want.done, vector_x, vector_y, block_column, block_line,
							frame_done);
				end
			end
		end
	end

	// send one symbol word after a random idle gap, predict at accept
	task automatic send_symbol(input logic reuse,
			input logic signed [DB-1:0] dx, input logic signed [DB-1:0] dy);
		while ($urandom_range(99) < send_idle_pct) begin
			blk_valid <= 1'b0;
			@(posedge clk);
		end
		blk_valid        <= 1'b1;
		reuse_prediction <= reuse;
		delta_x          <= dx;
		delta_y          <= dy;
		@(posedge clk);
		while (blk_stall)
			@(posedge clk);
		expected_vectors.push_back(predict_vector(reuse, dx, dy));
	endtask

	// stop sending and let every pending vector drain out of the pipe
	task automatic wait_idle();
		blk_valid <= 1'b0;
		@(posedge clk);
		while (expected_vectors.size() != 0)
			@(posedge clk);
		// two-stage pipe, a little margin on top
		repeat (4) @(posedge clk);
	endtask

	// write both frame size registers while the block is idle
	task automatic set_frame(input logic [mvp_pkg::CFG_DATA_BITS-1:0] across,
			input logic [mvp_pkg::CFG_DATA_BITS-1:0] down);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= mvp_pkg::REG_BLOCKS_ACROSS;
		cfg_data  <= across;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		frame_across = int'(across);
		cfg_index <= mvp_pkg::REG_BLOCKS_DOWN;
		cfg_data  <= down;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		frame_down = int'(down);
		cfg_valid <= 1'b0;
	endtask

	// one full-width single-row frame: writes every row entry once, so no
	// later frame shape can read an entry that was never written
	task automatic test_full_width_row();
		set_frame(7'd64, 7'd1);
		// top-left block, predictor zero
		send_symbol(1'b0, DELTA_MAX, DELTA_MIN);
		// left plus extreme delta saturates both ways
		send_symbol(1'b0, DELTA_MAX, DELTA_MIN);
		// reuse ignores the deltas
		send_symbol(1'b1, DELTA_MIN, DELTA_MAX);
		send_symbol(1'b0, DELTA_MIN, DELTA_MAX);
		send_symbol(1'b0, DELTA_MIN, DELTA_MIN);
		send_symbol(1'b0, '0, '0);
		// rest of the row, last one closes the frame
		repeat (58)
			send_symbol($urandom_range(99) < 25, random_delta(), random_delta());
	endtask

	// 4x3 frame: top-left, first row, first column, last column, interior
	task automatic test_neighbour_cases();
		int i;
		set_frame(7'd4, 7'd3);
		for (i = 0; i < 12; i++)
			send_symbol(i == 5 || i == 10, random_delta(), random_delta());
	endtask

	// one block wide: first column with up alone; 1x1: every block ends a frame
	task automatic test_narrow_frames();
		set_frame(7'd1, 7'd3);
		repeat (3)
			send_symbol(1'b0, random_delta(), random_delta());
		set_frame(7'd1, 7'd1);
		send_symbol(1'b0, DELTA_MAX, DELTA_MAX);
		send_symbol(1'b0, DELTA_MIN, DELTA_MIN);
	endtask

	// register clamping and a frame shrunk in the middle of a frame
	task automatic test_register_clamps();
		// zero sizes act as 1x1
		set_frame(7'd0, 7'd0);
		send_symbol(1'b0, random_delta(), random_delta());
		send_symbol(1'b1, random_delta(), random_delta());
		// oversized values act as 64x64, stop three blocks into the row
		set_frame(7'd127, 7'd100);
		repeat (3)
			send_symbol(1'b0, random_delta(), random_delta());
		// column 3 now sits past a 3-wide row: last column, then wrap
		set_frame(7'd3, 7'd127);
		repeat (3)
			send_symbol(1'b0, random_delta(), random_delta());
		// line 1 now past a 1-high frame: the row ends the frame
		set_frame(7'd3, 7'd1);
		repeat (3)
			send_symbol(1'b0, random_delta(), random_delta());
	endtask

	// random frame shapes, changed between bursts, often in mid frame
	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input int n_words);
		int                                 words_left;
		int                                 burst;
		int                                 pick;
		logic [mvp_pkg::CFG_DATA_BITS-1:0]  across;
		logic [mvp_pkg::CFG_DATA_BITS-1:0]  down;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		words_left     = n_words;
		while (words_left > 0) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				// small frames so rows and frames wrap often
				across = CB'($urandom_range(8, 1));
				down   = CB'($urandom_range(6, 1));
			end else if (pick < 90) begin
				across = CB'($urandom_range(ACROSS_MAX, 1));
				down   = CB'($urandom_range(DOWN_MAX, 1));
			end else begin
				// any register value, out of range included
				across = CB'($urandom_range(127, 0));
				down   = CB'($urandom_range(127, 0));
			end
			set_frame(across, down);
			burst = $urandom_range(120, 20);
			if (burst > words_left)
				burst = words_left;
			repeat (burst)
				send_symbol($urandom_range(99) < 25, random_delta(), random_delta());
			words_left -= burst;
		end
	endtask

	// main sequence
	initial begin
		send_idle_pct  = 16;
		recv_stall_pct = 55;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_full_width_row();
		test_neighbour_cases();
		test_narrow_frames();
		test_register_clamps();
		// receiver sparse first, then sender sparse, then full rate
		test_random_traffic(16, 55, 520);
		test_random_traffic(55, 16, 520);
		test_random_traffic(0, 0, 520);

		// drain, then keep watching for stray words
		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// hang guard, far above the slowest legal run
	initial begin
		#2000000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
